### rtl/obstacle_brake_supervisor_unit_defines.svh
// Assertion macros shared by the obstacle brake supervisor RTL.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef OBSTACLE_BRAKE_SUPERVISOR_UNIT_DEFINES_SVH
`define OBSTACLE_BRAKE_SUPERVISOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define OBSB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define OBSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/obsb_pkg.sv
// Package of the obstacle brake supervisor: codes, reset values, widths and
// the structs between the top level and the window. Depends on nothing.
`default_nettype none

package obsb_pkg;

   // Window depth default
   localparam int unsigned WINDOW_DEPTH_DEF = 5;

   // Field widths
   localparam int unsigned DIST_W   = 16;
   localparam int unsigned WIN_W    = 11;
   localparam int unsigned THR_W    = 11;
   localparam int unsigned BAND_W   = 8;
   localparam int unsigned TREND_W  = 12;

   // Valid reading range in mm
   localparam logic [DIST_W-1:0] VALID_MIN_MM = 16'd1;
   localparam logic [DIST_W-1:0] VALID_MAX_MM = 16'd2000;

   // Register reset values
   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 11'd150;
   localparam logic [BAND_W-1:0] BAND_RESET      = 8'd10;

   // Register indexes
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_BAND      = 1'b1;

   // Request kinds
   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_CLEAR  = 1'b1;

   // Mode codes
   localparam logic [1:0] MODE_CLEAR      = 2'd0;
   localparam logic [1:0] MODE_BRAKING    = 2'd1;
   localparam logic [1:0] MODE_MONITORING = 2'd2;

   // Notice codes
   localparam logic [1:0] NOTICE_NONE     = 2'd0;
   localparam logic [1:0] NOTICE_ASSERTED = 2'd1;
   localparam logic [1:0] NOTICE_RELEASED = 2'd2;

   typedef struct packed {
      logic             push;
      logic             clear;
      logic [WIN_W-1:0] data;
   } win_ctrl_type;

   typedef struct packed {
      logic             push_fills;   // window is full once this push lands
      logic [WIN_W-1:0] oldest_after; // oldest entry once this push lands
   } win_stat_type;

endpackage

`default_nettype wire

### rtl/obsb_window.sv
// Distance window of the obstacle brake supervisor: shift storage and fill
// count, with a look-ahead of the oldest entry after a push. Uses obsb_pkg.
`default_nettype none

module obsb_window #(
   parameter int unsigned DEPTH = obsb_pkg::WINDOW_DEPTH_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  obsb_pkg::win_ctrl_type     ctrl,
   output obsb_pkg::win_stat_type     stat
);

   localparam int unsigned FILL_W = $clog2(DEPTH + 1);

   logic [obsb_pkg::WIN_W-1:0] entry_ff [DEPTH];
   logic [obsb_pkg::WIN_W-1:0] entry_in [DEPTH];
   logic [FILL_W-1:0]          fill_ff;
   logic [FILL_W-1:0]          fill_in;
   logic                       full_now;

   assign full_now = (fill_ff == FILL_W'(DEPTH));

   always_comb begin
      entry_in = entry_ff;
      fill_in  = fill_ff;
      if (ctrl.push) begin
         if (full_now) begin
            // shift out the oldest, append at the tail
            for (int i = 0; i < DEPTH - 1; i++) begin
               entry_in[i] = entry_ff[i+1];
            end
            entry_in[DEPTH-1] = ctrl.data;
         end else begin
            for (int i = 0; i < DEPTH; i++) begin
               if (fill_ff == FILL_W'(i)) begin
                  entry_in[i] = ctrl.data;
               end
            end
            fill_in = fill_ff + FILL_W'(1);
         end
      end
      if (ctrl.clear) begin
         fill_in = '0;
      end
   end

   assign stat.push_fills   = (fill_ff >= FILL_W'(DEPTH - 1));
   assign stat.oldest_after = full_now ? entry_ff[1] : entry_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

### rtl/obstacle_brake_supervisor_unit.sv
// Top level of the obstacle brake supervisor: request register, mode
// machine, configuration registers and response register.
// Uses obsb_pkg, obsb_window and obstacle_brake_supervisor_unit_defines.svh.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+----------------------------------
//   req     | in  | req_tvalid/tready   | tdata: left, right; tuser: action
//   rsp     | out | rsp_tvalid/tready   | tdata: mode, blocked, notice, ...
//   csr     | in  | csr_valid/ready     | csr_index, csr_data
//
// One request a cycle sustained while responses are taken; a request taken
// is held in the request register and then moves into the response register,
// from which its response is offered until it is taken.
// The mode machine and the window update as a request leaves the request
// register, so back-to-back requests see each other's state.
// Reset (synchronous, active high) sets clear mode, empties the window and
// loads the default threshold and band; window contents are not cleared.
// A stalled response holds; the request register takes a request while it is
// empty or while its request can move into the response register.
`default_nettype none
`include "obstacle_brake_supervisor_unit_defines.svh"

module obstacle_brake_supervisor_unit #(
   parameter int unsigned WINDOW_DEPTH = obsb_pkg::WINDOW_DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [15:0] left_distance, [31:16] right_distance
   input  wire  [0:0]  req_tuser,   // [0] action
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] brake_mode, [2] drive_blocked,
                                    // [4:3] brake_notice, [5] send_brake,
                                    // [6] reading_accepted, [7] zero
   // configuration write channel
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [0:0]  csr_index,
   input  wire  [10:0] csr_data
);

   // ---------------- configuration registers ----------------
   logic [obsb_pkg::THR_W-1:0]  threshold_ff;
   logic [obsb_pkg::BAND_W-1:0] band_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= obsb_pkg::THRESHOLD_RESET;
         band_ff      <= obsb_pkg::BAND_RESET;
      end else if (csr_valid) begin
         unique case (csr_index[0])
            obsb_pkg::CSR_THRESHOLD: threshold_ff <= csr_data;
            obsb_pkg::CSR_BAND:      band_ff      <= csr_data[obsb_pkg::BAND_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- request register ----------------
   logic                         hold_valid_ff;
   logic                         hold_action_ff;
   logic [obsb_pkg::DIST_W-1:0]  hold_left_ff;
   logic [obsb_pkg::DIST_W-1:0]  hold_right_ff;
   logic                         rsp_valid_ff;
   logic                         advance;

   // advance: the held request moves into the response register
   assign advance    = hold_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !hold_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_tready) begin
         hold_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         hold_action_ff <= req_tuser[0];
         hold_left_ff   <= req_tdata[15:0];
         hold_right_ff  <= req_tdata[31:16];
      end
   end

   // ---------------- step logic ----------------
   logic [1:0]                  mode_ff, mode_in;
   logic                        blocked_ff, blocked_in;
   logic [1:0]                  notice;
   logic                        send;
   logic                        valid_pair;
   logic                        either_below;
   logic                        clear_win;
   logic [obsb_pkg::WIN_W-1:0]  nearer;
   logic [obsb_pkg::TREND_W-1:0] newest_ext, oldest_ext, band_ext;
   logic                        approach, retreat;
   obsb_pkg::win_ctrl_type      win_ctrl;
   obsb_pkg::win_stat_type      win_stat;

   assign valid_pair = (hold_action_ff == obsb_pkg::ACTION_SAMPLE)
                    && (hold_left_ff  >= obsb_pkg::VALID_MIN_MM)
                    && (hold_left_ff  <= obsb_pkg::VALID_MAX_MM)
                    && (hold_right_ff >= obsb_pkg::VALID_MIN_MM)
                    && (hold_right_ff <= obsb_pkg::VALID_MAX_MM);

   assign either_below =
      (hold_left_ff  < {{(obsb_pkg::DIST_W-obsb_pkg::THR_W){1'b0}}, threshold_ff}) ||
      (hold_right_ff < {{(obsb_pkg::DIST_W-obsb_pkg::THR_W){1'b0}}, threshold_ff});

   // nearer reading fits 11 bits once the pair is in range
   assign nearer = (hold_left_ff < hold_right_ff) ? hold_left_ff[obsb_pkg::WIN_W-1:0]
                                                  : hold_right_ff[obsb_pkg::WIN_W-1:0];

   // trend of the window after the push: newest is this sample
   assign newest_ext = {1'b0, nearer};
   assign oldest_ext = {1'b0, win_stat.oldest_after};
   assign band_ext   = {{(obsb_pkg::TREND_W-obsb_pkg::BAND_W){1'b0}}, band_ff};
   assign approach   = (newest_ext + band_ext) < oldest_ext;
   assign retreat    = newest_ext > (oldest_ext + band_ext);

   always_comb begin
      mode_in    = mode_ff;
      blocked_in = blocked_ff;
      notice     = obsb_pkg::NOTICE_NONE;
      send       = 1'b0;
      clear_win  = 1'b0;
      if (hold_action_ff == obsb_pkg::ACTION_CLEAR) begin
         // external clear: leave braking for monitoring
         if (mode_ff == obsb_pkg::MODE_BRAKING) begin
            mode_in    = obsb_pkg::MODE_MONITORING;
            blocked_in = 1'b0;
            clear_win  = 1'b1;
         end
      end else if (valid_pair) begin
         unique case (mode_ff)
            obsb_pkg::MODE_CLEAR: begin
               if (either_below) begin
                  mode_in    = obsb_pkg::MODE_BRAKING;
                  blocked_in = 1'b1;
                  clear_win  = 1'b1;
                  notice     = obsb_pkg::NOTICE_ASSERTED;
                  send       = 1'b1;
               end
            end
            obsb_pkg::MODE_BRAKING: begin
               send = 1'b1;
            end
            obsb_pkg::MODE_MONITORING: begin
               if (!either_below) begin
                  mode_in    = obsb_pkg::MODE_CLEAR;
                  blocked_in = 1'b0;
                  clear_win  = 1'b1;
                  notice     = obsb_pkg::NOTICE_RELEASED;
               end else if (win_stat.push_fills) begin
                  if (approach) begin
                     // closing in beyond the band: brake again
                     mode_in    = obsb_pkg::MODE_BRAKING;
                     blocked_in = 1'b1;
                     clear_win  = 1'b1;
                     notice     = obsb_pkg::NOTICE_ASSERTED;
                     send       = 1'b1;
                  end else if (retreat) begin
                     clear_win = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign win_ctrl.push  = advance && valid_pair;
   assign win_ctrl.clear = advance && clear_win;
   assign win_ctrl.data  = nearer;

   obsb_window #(
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .ctrl  (win_ctrl),
      .stat  (win_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= obsb_pkg::MODE_CLEAR;
         blocked_ff <= 1'b0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         blocked_ff <= blocked_in;
      end
   end

   // ---------------- response register ----------------
   logic [7:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {1'b0, valid_pair, send, notice, blocked_in, mode_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   `OBSB_ASSERT_IMPLY(a_blocked_matches_mode, clock, reset, rsp_valid_ff,
      rsp_data_ff[2] == (rsp_data_ff[1:0] == obsb_pkg::MODE_BRAKING))
   `OBSB_ASSERT_IMPLY(a_send_only_braking, clock, reset, rsp_valid_ff && rsp_data_ff[5],
      rsp_data_ff[1:0] == obsb_pkg::MODE_BRAKING)
   `OBSB_ASSERT_IMPLY(a_release_to_clear, clock, reset,
      rsp_valid_ff && (rsp_data_ff[4:3] == obsb_pkg::NOTICE_RELEASED),
      rsp_data_ff[1:0] == obsb_pkg::MODE_CLEAR)
   `OBSB_ASSERT_IMPLY(a_rejected_is_quiet, clock, reset, rsp_valid_ff && !rsp_data_ff[6],
      (rsp_data_ff[4:3] == obsb_pkg::NOTICE_NONE) && !rsp_data_ff[5])
   `OBSB_ASSERT_NEXT(a_state_tracks_rsp, clock, reset, advance,
      (mode_ff == rsp_data_ff[1:0]) && (blocked_ff == rsp_data_ff[2]))

endmodule

`default_nettype wire
